[hw/rtl/iterative_point_smoother_unit_assert.svh]
// ----------------------------------------------------------------------------
// iterative point smoother assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ITERATIVE_POINT_SMOOTHER_UNIT_ASSERT_SVH
`define ITERATIVE_POINT_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication
`define IPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ips_pkg.sv]
// ----------------------------------------------------------------------------
// ips_pkg
// types, constants and arithmetic helpers of the iterative point smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ips_pkg;

  localparam int CoordW        = 32;
  localparam int ThreshW       = 16;
  localparam int PassesRunW    = 7;
  localparam int DefMaxPoints  = 64;
  localparam int DefMaxPasses  = 64;

  localparam logic [ThreshW-1:0] ThreshReset = 16'd2621;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [CoordW-1:0]        chg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  localparam int PointW = $bits(point_t);

  // (prev + 2*cur + next) >>> 2
  function automatic coord_t smooth_tap(coord_t prv, coord_t cur, coord_t nxt);
    logic [CoordW+1:0] sum;
    sum = {{2{prv[CoordW-1]}}, prv} + {cur[CoordW-1], cur, 1'b0}
        + {{2{nxt[CoordW-1]}}, nxt};
    return coord_t'(sum[CoordW+1:2]);
  endfunction

  function automatic chg_t abs_diff(coord_t a, coord_t b);
    logic [CoordW:0] d;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (d[CoordW]) begin
      d = -d;
    end
    return d[CoordW-1:0];
  endfunction

endpackage

[hw/rtl/iterative_point_smoother_unit.sv]
// loading: points load one per cycle until the final point; each smoothing pass
//   then sweeps the stored points through the one read and one write port of
//   the point memory
// emission: after the last pass, results leave one per cycle unless out_stall_i holds them
// reset: control state clears and the threshold returns to 2621, the point
//   memory is not cleared
// ----------------------------------------------------------------------------
// iterative_point_smoother_unit
// collects a 3d polyline, smooths it in place over passes, emits all stored points
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iterative_point_smoother_unit
  import ips_pkg::*;
#(
  parameter int MaxPoints = DefMaxPoints,
  parameter int MaxPasses = DefMaxPasses
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [ThreshW-1:0]      cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  input  logic                    final_point_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [CoordW-1:0] smooth_x_o,
  output logic signed [CoordW-1:0] smooth_y_o,
  output logic signed [CoordW-1:0] smooth_z_o,
  output logic                    end_of_set_o,
  output logic                    points_dropped_o,
  output logic [PassesRunW-1:0]   passes_run_o
);

  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW  = $clog2(MaxPoints + 1);
  localparam int PassW = $clog2(MaxPasses + 1);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StSweep = 6'b000010,
    StDrain = 6'b000100,
    StCheck = 6'b001000,
    StJudge = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [ThreshW-1:0]  thr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [PassW-1:0]    pass_q, pass_d;
  chg_t                prev_q, prev_d;
  chg_t                max_q, max_d;
  logic [AddrW-1:0]    ra_q, ra_d;
  logic                issued_all_q, issued_all_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AddrW-1:0]    ridx_q, ridx_d;
  logic                rd_last_q, rd_last_d;
  point_t              prev_new_q, prev_new_d;
  point_t              cur_old_q, cur_old_d;
  logic                dv_q, dv_d;
  point_t              dv_old_q, dv_new_q;
  logic signed [CoordW:0]          gain_q;
  logic [ThreshW+CoordW-1:0]       prod_q;
  logic                out_valid_q, out_valid_d;
  point_t              out_pt_q;
  logic                out_last_q, out_drop_q;
  logic [PassesRunW-1:0] out_passes_q;

  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr;
  point_t              ram_wdata, rd_pt, nv_pt;
  logic [PointW-1:0]   ram_rdata;

  logic                in_xfer, cfg_xfer, store_ok, out_free, ra_last, proc;
  logic                sweep_we, issue_ok, consume, keep_going;
  logic [CntW-1:0]     last_idx;
  chg_t                dx, dy, dz, dmax;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign store_ok    = (cnt_q < CntW'(MaxPoints));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_idx    = cnt_q - CntW'(1);
  assign ra_last     = (CntW'(ra_q) == last_idx);

  assign rd_pt = point_t'(ram_rdata);

  // sweep datapath
  assign proc     = rd_vld_q && ((state_q == StSweep) || (state_q == StDrain));
  assign sweep_we = proc && (ridx_q > AddrW'(1));
  assign nv_pt.x  = smooth_tap(prev_new_q.x, cur_old_q.x, rd_pt.x);
  assign nv_pt.y  = smooth_tap(prev_new_q.y, cur_old_q.y, rd_pt.y);
  assign nv_pt.z  = smooth_tap(prev_new_q.z, cur_old_q.z, rd_pt.z);

  assign dx = abs_diff(dv_old_q.x, dv_new_q.x);
  assign dy = abs_diff(dv_old_q.y, dv_new_q.y);
  assign dz = abs_diff(dv_old_q.z, dv_new_q.z);

  always_comb begin
    dmax = max_q;
    if (dx > dmax) begin
      dmax = dx;
    end
    if (dy > dmax) begin
      dmax = dy;
    end
    if (dz > dmax) begin
      dmax = dz;
    end
  end

  // emission handshake
  assign issue_ok = (state_q == StEmit) && !issued_all_q && (!rd_vld_q || out_free);
  assign consume  = (state_q == StEmit) && rd_vld_q && out_free;

  assign keep_going = (prev_q != '0)
                   && ($signed({gain_q, {ThreshW{1'b0}}}) > $signed({1'b0, prod_q}))
                   && (pass_q < PassW'(MaxPasses));

  // memory ports
  always_comb begin
    if (state_q == StIdle) begin
      ram_we    = in_xfer && store_ok;
      ram_waddr = cnt_q[AddrW-1:0];
      ram_wdata = '{x: coord_x_i, y: coord_y_i, z: coord_z_i};
    end else begin
      ram_we    = sweep_we;
      ram_waddr = ridx_q - AddrW'(1);
      ram_wdata = nv_pt;
    end
  end

  assign ram_re = (state_q == StSweep) || issue_ok;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    pass_d       = pass_q;
    prev_d       = prev_q;
    max_d        = max_q;
    ra_d         = ra_q;
    issued_all_d = issued_all_q;
    rd_vld_d     = 1'b0;
    ridx_d       = ra_q;
    rd_last_d    = rd_last_q;
    prev_new_d   = prev_new_q;
    cur_old_d    = cur_old_q;
    dv_d         = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;

    if (proc) begin
      if (ridx_q == '0) begin
        prev_new_d = rd_pt;
      end else if (ridx_q == AddrW'(1)) begin
        cur_old_d = rd_pt;
      end else begin
        prev_new_d = nv_pt;
        cur_old_d  = rd_pt;
        dv_d       = 1'b1;
      end
    end
    if (dv_q) begin
      max_d = dmax;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (store_ok) begin
            cnt_d = cnt_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (final_point_i) begin
            state_d = StSweep;
            pass_d  = '0;
            ra_d    = '0;
            max_d   = '0;
          end
        end
      end
      StSweep: begin
        rd_vld_d = 1'b1;
        if (ra_last) begin
          state_d = StDrain;
        end else begin
          ra_d = ra_q + AddrW'(1);
        end
      end
      StDrain: begin
        if (!rd_vld_q && !dv_q) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        pass_d = pass_q + PassW'(1);
        ra_d   = '0;
        if (pass_q == '0) begin
          prev_d  = max_q;
          max_d   = '0;
          state_d = StSweep;
        end else begin
          state_d = StJudge;
        end
      end
      StJudge: begin
        prev_d = max_q;
        max_d  = '0;
        ra_d   = '0;
        if (keep_going) begin
          state_d = StSweep;
        end else begin
          state_d      = StEmit;
          issued_all_d = 1'b0;
        end
      end
      StEmit: begin
        rd_vld_d = rd_vld_q && !consume;
        if (issue_ok) begin
          rd_vld_d  = 1'b1;
          rd_last_d = ra_last;
          if (ra_last) begin
            issued_all_d = 1'b1;
          end else begin
            ra_d = ra_q + AddrW'(1);
          end
        end
        if (consume) begin
          out_valid_d = 1'b1;
        end
        if (issued_all_q && !rd_vld_q) begin
          state_d = StIdle;
          cnt_d   = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      thr_q        <= ThreshReset;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      pass_q       <= '0;
      prev_q       <= '0;
      max_q        <= '0;
      ra_q         <= '0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      dv_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_xfer) begin
        thr_q <= cfg_data_i;
      end
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      pass_q       <= pass_d;
      prev_q       <= prev_d;
      max_q        <= max_d;
      ra_q         <= ra_d;
      issued_all_q <= issued_all_d;
      rd_vld_q     <= rd_vld_d;
      dv_q         <= dv_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= ridx_d;
    rd_last_q  <= rd_last_d;
    prev_new_q <= prev_new_d;
    cur_old_q  <= cur_old_d;
    dv_old_q   <= cur_old_q;
    dv_new_q   <= nv_pt;
    gain_q     <= $signed({1'b0, prev_q}) - $signed({1'b0, max_q});
    prod_q     <= thr_q * prev_q;
    if (consume) begin
      out_pt_q     <= rd_pt;
      out_last_q   <= rd_last_q;
      out_drop_q   <= ovf_q;
      out_passes_q <= PassesRunW'(pass_q);
    end
  end

  ips_ram #(
    .Width (PointW),
    .Depth (MaxPoints)
  ) u_point_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ra_q),
    .rd_data_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign smooth_x_o       = out_pt_q.x;
  assign smooth_y_o       = out_pt_q.y;
  assign smooth_z_o       = out_pt_q.z;
  assign end_of_set_o     = out_last_q;
  assign points_dropped_o = out_drop_q;
  assign passes_run_o     = out_passes_q;

`include "iterative_point_smoother_unit_assert.svh"

  `IPS_ASSERT_IMP(a_sweep_wr_interior, sweep_we,
    (ram_waddr != '0) && (CntW'(ram_waddr) < last_idx),
    "sweep write outside the interior points")
  `IPS_ASSERT_NXT(a_emit_rdata_held, (state_q == StEmit) && rd_vld_q && !out_free,
    $stable(ram_rdata), "pending emit data lost while output stalled")
  `IPS_ASSERT_IMP(a_pass_bound, 1'b1, pass_q <= PassW'(MaxPasses),
    "pass count beyond limit")
  `IPS_ASSERT_NXT(a_pass_cap_stops, (state_q == StJudge) && (pass_q == PassW'(MaxPasses)),
    state_q == StEmit, "smoothing continued past the pass limit")

endmodule

[hw/rtl/ips_ram.sv]
// ----------------------------------------------------------------------------
// ips_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ips_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[test/tb_iterative_point_smoother_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterative_point_smoother_unit
// drives point sets through the smoother under random valid gaps and result
// stalls, predicts every smoothed point with an in-bench fixed-point model of
// the passes and compares each result transfer field by field
// ----------------------------------------------------------------------------

module tb_iterative_point_smoother_unit;
  import ips_pkg::*;

  localparam int IdleLimit    = 20000;
  localparam int DrainCycles  = 24;
  localparam int RandomPoints = 10;

  typedef enum int {
    ShapeNoise,
    ShapeWalk,
    ShapeMixed
  } shape_e;

  typedef struct {
    coord_t                x;
    coord_t                y;
    coord_t                z;
    logic                  end_of_set;
    logic                  dropped;
    logic [PassesRunW-1:0] passes;
  } smooth_pt_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [ThreshW-1:0]    cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  coord_t                coord_x_i     = '0;
  coord_t                coord_y_i     = '0;
  coord_t                coord_z_i     = '0;
  logic                  final_point_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  coord_t                smooth_x_o;
  coord_t                smooth_y_o;
  coord_t                smooth_z_o;
  logic                  end_of_set_o;
  logic                  points_dropped_o;
  logic [PassesRunW-1:0] passes_run_o;

  longint             line_pt[3][DefMaxPoints];
  int                 stored_pts    = 0;
  bit                 overflow_flag = 1'b0;
  logic [ThreshW-1:0] threshold     = ThreshReset;
  smooth_pt_t         smoothed_q[$];
  int                 errors        = 0;
  int                 idle_cycles   = 0;
  int                 stall_left    = 0;
  bit                 in_burst      = 1'b0;
  bit                 out_burst     = 1'b0;

  always #1 clk_i = ~clk_i;

  iterative_point_smoother_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .coord_x_i        (coord_x_i),
    .coord_y_i        (coord_y_i),
    .coord_z_i        (coord_z_i),
    .final_point_i    (final_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .smooth_x_o       (smooth_x_o),
    .smooth_y_o       (smooth_y_o),
    .smooth_z_o       (smooth_z_o),
    .end_of_set_o     (end_of_set_o),
    .points_dropped_o (points_dropped_o),
    .passes_run_o     (passes_run_o)
  );

  function automatic int draw_wait(bit burst);
    if (burst || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return int'($urandom_range(0, 19));
  endfunction

  // one in-place pass over all axes, returns the largest per-axis change
  function automatic longint pass_change(int n);
    longint most;
    longint old;
    longint upd;
    longint diff;
    most = 0;
    for (int ax = 0; ax < 3; ax++) begin
      for (int i = 1; i + 1 < n; i++) begin
        old  = line_pt[ax][i];
        upd  = (line_pt[ax][i-1] + 2 * old + line_pt[ax][i+1]) >>> 2;
        diff = (old >= upd) ? old - upd : upd - old;
        line_pt[ax][i] = upd;
        if (diff > most) begin
          most = diff;
        end
      end
    end
    return most;
  endfunction

  function automatic void check_field(string name, logic [CoordW-1:0] want,
                                      logic [CoordW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  task automatic send_point(coord_t px, coord_t py, coord_t pz, logic last);
    int         gap;
    int         passes;
    longint     prev_chg;
    longint     chg;
    bit         more;
    smooth_pt_t res;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    coord_x_i     <= px;
    coord_y_i     <= py;
    coord_z_i     <= pz;
    final_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (stored_pts < DefMaxPoints) begin
      line_pt[0][stored_pts] = longint'(px);
      line_pt[1][stored_pts] = longint'(py);
      line_pt[2][stored_pts] = longint'(pz);
      stored_pts++;
    end else begin
      overflow_flag = 1'b1;
    end
    if (last) begin
      prev_chg = pass_change(stored_pts);
      passes   = 1;
      more     = 1'b1;
      while (more && passes < DefMaxPasses) begin
        chg = pass_change(stored_pts);
        passes++;
        more = (prev_chg != 0) &&
               ((prev_chg - chg) * 65536 > longint'(threshold) * prev_chg);
        prev_chg = chg;
      end
      for (int i = 0; i < stored_pts; i++) begin
        res.x          = coord_t'(line_pt[0][i]);
        res.y          = coord_t'(line_pt[1][i]);
        res.z          = coord_t'(line_pt[2][i]);
        res.end_of_set = (i + 1 == stored_pts);
        res.dropped    = overflow_flag;
        res.passes     = passes[PassesRunW-1:0];
        smoothed_q     = {smoothed_q, res};
      end
      stored_pts    = 0;
      overflow_flag = 1'b0;
    end
  endtask

  task automatic send_set(int count, shape_e shape);
    coord_t walk[3];
    coord_t pt[3];
    for (int a = 0; a < 3; a++) begin
      walk[a] = coord_t'($urandom);
    end
    for (int i = 0; i < count; i++) begin
      for (int a = 0; a < 3; a++) begin
        case (shape)
          ShapeWalk: begin
            walk[a] = walk[a] + coord_t'($urandom_range(0, 131072)) - 65536;
            pt[a]   = walk[a];
          end
          ShapeMixed: begin
            case ($urandom_range(0, 4))
              0: pt[a] = {1'b0, {(CoordW-1){1'b1}}};
              1: pt[a] = {1'b1, {(CoordW-1){1'b0}}};
              2: pt[a] = '0;
              3: pt[a] = '1;
              default: pt[a] = coord_t'($urandom);
            endcase
          end
          default: begin
            pt[a] = coord_t'($urandom);
          end
        endcase
      end
      send_point(pt[0], pt[1], pt[2], i == count - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [ThreshW-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    threshold = value;
  endtask

  // single point, two points, full-scale swings, flat line
  task automatic test_extremes();
    coord_t cmax;
    coord_t cmin;
    cmax = {1'b0, {(CoordW-1){1'b1}}};
    cmin = {1'b1, {(CoordW-1){1'b0}}};
    send_point(cmax, cmin, '0, 1'b1);
    send_point(cmin, cmin, cmin, 1'b0);
    send_point(cmax, cmax, cmax, 1'b1);
    in_burst = 1'b1;
    send_point(cmax, cmax, cmin, 1'b0);
    send_point(cmin, cmin, cmax, 1'b0);
    send_point(cmax, cmax, cmin, 1'b1);
    in_burst = 1'b0;
    send_point('0, '1, 32'sd1, 1'b0);
    send_point(cmax, cmin, '1, 1'b0);
    send_point(cmin, cmax, '0, 1'b0);
    send_point('1, '0, cmax, 1'b0);
    send_point(32'sd1, 32'sd1, cmin, 1'b1);
    for (int i = 0; i < 4; i++) begin
      send_point(32'sh0001_8000, -32'sh0002_0000, '1, i == 3);
    end
  endtask

  // final point dropped on a full store
  task automatic test_store_full();
    send_set(DefMaxPoints + 1, ShapeNoise);
  endtask

  // zero threshold on a smooth line runs toward the pass cap, then full threshold on noise
  task automatic test_pass_limit();
    write_threshold('0);
    send_set(16, ShapeWalk);
    write_threshold('1);
    send_set(4, ShapeNoise);
  endtask

  task automatic test_random();
    int sent;
    int sets;
    int size;
    sent = 0;
    sets = 0;
    while (sent < RandomPoints) begin
      if (sets % 3 == 0) begin
        case ($urandom_range(0, 3))
          0: write_threshold('0);
          1: write_threshold('1);
          2: write_threshold(ThreshReset);
          default: write_threshold(ThreshW'($urandom_range(0, 65535)));
        endcase
      end
      in_burst  = ($urandom_range(0, 4) == 0);
      out_burst = ($urandom_range(0, 4) == 0);
      size = int'($urandom_range(1, 8));
      send_set(size, shape_e'($urandom_range(0, 2)));
      sent += size;
      sets++;
    end
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      stall_left = draw_wait(out_burst);
    end else if (out_valid_o && stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin : result_check
    smooth_pt_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (smoothed_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual x %h",
                 $time, smooth_x_o);
      end else begin
        want = smoothed_q.pop_front();
        check_field("smooth_x", want.x, smooth_x_o);
        check_field("smooth_y", want.y, smooth_y_o);
        check_field("smooth_z", want.z, smooth_z_o);
        check_field("end_of_set", CoordW'(want.end_of_set), CoordW'(end_of_set_o));
        check_field("points_dropped", CoordW'(want.dropped), CoordW'(points_dropped_o));
        check_field("passes_run", CoordW'(want.passes), CoordW'(passes_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, IdleLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_store_full();
    test_pass_limit();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
